[rtl/core/cc_pkg.sv]
// ----------------------------------------------------------------------------
// cc_pkg
// Shared constants and codes of the cross-correlate and accumulate block.
// ----------------------------------------------------------------------------
package cc_pkg;

	localparam int MAX_ANTENNAS_DEF = 4;
	localparam int MAX_CHANNELS_DEF = 64;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int ACC_BITS_DEF     = 48;

	localparam int CNT_BITS    = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int ANT_CFG_BITS  = 3;
	localparam int CHAN_CFG_BITS = 7;
	localparam int CFG_BITS      = 7;

	localparam logic [ANT_CFG_BITS-1:0]  ANT_CFG_RESET  = 3'd4;
	localparam logic [CHAN_CFG_BITS-1:0] CHAN_CFG_RESET = 7'd64;

	typedef enum logic {
		REG_ANTENNAS = 1'b0,
		REG_CHANNELS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_CLEAR     = 2'd0,
		CMD_LOAD      = 2'd1,
		CMD_CORRELATE = 2'd2,
		CMD_READ      = 2'd3
	} cmd_t;

endpackage

[rtl/core/cc_ram.sv]
// ----------------------------------------------------------------------------
// cc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/cc_front.sv]
// ----------------------------------------------------------------------------
// cc_front
// Input side: range-checks each word, works out its store addresses and
// packs it for the command queue.
// ----------------------------------------------------------------------------
module cc_front #(
	parameter int MAX_ANTENNAS = cc_pkg::MAX_ANTENNAS_DEF,
	parameter int MAX_CHANNELS = cc_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = cc_pkg::SAMPLE_BITS_DEF,
	localparam int NB   = MAX_ANTENNAS * (MAX_ANTENNAS - 1) / 2,
	localparam int SD   = MAX_ANTENNAS * 2 * MAX_CHANNELS,
	localparam int AD   = NB * 4 * MAX_CHANNELS,
	localparam int AN_W = $clog2(MAX_ANTENNAS),
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	localparam int BL_W = (NB > 1) ? $clog2(NB) : 1,
	localparam int SA_W = $clog2(SD),
	localparam int AA_W = (AD > 1) ? $clog2(AD) : 1,
	localparam int IW   = 2 + 1 + AN_W + 1 + BL_W + SA_W + AA_W + 2 * SAMPLE_BITS
) (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [AN_W-1:0]               antenna,
	input  logic                          polarisation,
	input  logic [CH_W-1:0]               channel,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic                          antenna_ok,
	input  logic [BL_W-1:0]               baseline,
	input  logic [1:0]                    product,
	output logic                          push,
	input  logic                          full,
	output logic [IW-1:0]                 item
);

	logic            ok;
	logic [SA_W-1:0] sa;
	logic [AA_W-1:0] aa;
	int              sa_full;
	int              aa_full;

	always_comb begin
		sa_full = (int'(antenna) * 2 + int'(polarisation)) * MAX_CHANNELS + int'(channel);
		aa_full = (int'(baseline) * 4 + int'(product)) * MAX_CHANNELS + int'(channel);
		sa = sa_full[SA_W-1:0];
		aa = aa_full[AA_W-1:0];
		// a load needs a real antenna, a read a real baseline
		if (cmd == cc_pkg::CMD_LOAD) begin
			ok = (int'(antenna) < MAX_ANTENNAS) && (int'(channel) < MAX_CHANNELS);
		end else begin
			ok = (int'(baseline) < NB) && (int'(channel) < MAX_CHANNELS);
		end
	end

	assign in_stall = full;
	assign push     = in_valid && !full;
	assign item     = {cmd, ok, antenna, antenna_ok, baseline, sa, aa, sample_re, sample_im};

endmodule

[rtl/core/cc_queue.sv]
// ----------------------------------------------------------------------------
// cc_queue
// Short FIFO between the input side and the execution side.
// ----------------------------------------------------------------------------
module cc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cc_pkg::QUEUE_DEPTH,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      fill_q;

	assign full     = (int'(fill_q) == DEPTH);
	assign nonempty = (fill_q != '0);
	assign rdata    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (int'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (int'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/cc_div.sv]
// ----------------------------------------------------------------------------
// cc_div
// Two-lane restoring divider: signed accumulator by unsigned count, one
// quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module cc_div #(
	parameter int ACC_BITS = cc_pkg::ACC_BITS_DEF,
	localparam int CB  = cc_pkg::CNT_BITS,
	localparam int IXW = $clog2(ACC_BITS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [ACC_BITS-1:0] num_re,
	input  logic signed [ACC_BITS-1:0] num_im,
	input  logic [CB-1:0]              den,
	output logic                       done,
	output logic signed [ACC_BITS-1:0] quo_re,
	output logic signed [ACC_BITS-1:0] quo_im
);

	logic [ACC_BITS-1:0] quo_q [2];
	logic [CB:0]         rem_q [2];
	logic                neg_q [2];
	logic [CB-1:0]       den_q;
	logic [IXW-1:0]      step_q;
	logic                busy_q;
	logic                done_q;
	logic [CB:0]         trial [2];
	logic                fits  [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = {rem_q[l][CB-1:0], quo_q[l][ACC_BITS-1]};
			fits[l]  = (trial[l] >= {1'b0, den_q});
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q[0] <= num_re[ACC_BITS-1];
			neg_q[1] <= num_im[ACC_BITS-1];
			quo_q[0] <= num_re[ACC_BITS-1] ? -num_re : num_re;
			quo_q[1] <= num_im[ACC_BITS-1] ? -num_im : num_im;
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			den_q    <= den;
		end else if (busy_q) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= fits[l] ? trial[l] - {1'b0, den_q} : trial[l];
				quo_q[l] <= {quo_q[l][ACC_BITS-2:0], fits[l]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (int'(step_q) == ACC_BITS - 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign quo_re = neg_q[0] ? -quo_q[0] : quo_q[0];
	assign quo_im = neg_q[1] ? -quo_q[1] : quo_q[1];

endmodule

[rtl/core/cc_back.sv]
// ----------------------------------------------------------------------------
// cc_back
// Execution side: spectrum store, accumulator store, baseline walk with the
// cross-multiply pipeline, clearing sweep, reads with normalisation and the
// output register.
// ----------------------------------------------------------------------------
module cc_back #(
	parameter int MAX_ANTENNAS = cc_pkg::MAX_ANTENNAS_DEF,
	parameter int MAX_CHANNELS = cc_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = cc_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_BITS     = cc_pkg::ACC_BITS_DEF,
	localparam int NB   = MAX_ANTENNAS * (MAX_ANTENNAS - 1) / 2,
	localparam int SD   = MAX_ANTENNAS * 2 * MAX_CHANNELS,
	localparam int AD   = NB * 4 * MAX_CHANNELS,
	localparam int AN_W = $clog2(MAX_ANTENNAS),
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	localparam int BL_W = (NB > 1) ? $clog2(NB) : 1,
	localparam int SA_W = $clog2(SD),
	localparam int AA_W = (AD > 1) ? $clog2(AD) : 1,
	localparam int IW   = 2 + 1 + AN_W + 1 + BL_W + SA_W + AA_W + 2 * SAMPLE_BITS,
	localparam int CB   = cc_pkg::CNT_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [IW-1:0]                         item,
	input  logic                                  item_valid,
	output logic                                  item_pop,
	input  logic [cc_pkg::ANT_CFG_BITS-1:0]       antennas_in_use,
	input  logic [cc_pkg::CHAN_CFG_BITS-1:0]      channels_in_use,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ACC_BITS-1:0]            vis_re,
	output logic signed [ACC_BITS-1:0]            vis_im,
	output logic [CB-1:0]                         fft_count
);

	localparam int SB  = SAMPLE_BITS;
	localparam int PW  = 2 * SB;
	localparam int SW  = ((ACC_BITS > PW + 1) ? ACC_BITS : PW + 1) + 1;
	localparam int NW  = $clog2(MAX_ANTENNAS + 1);
	localparam int NCW = $clog2(MAX_CHANNELS + 1);

	typedef enum logic [7:0] {
		S_CLR   = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_CORR  = 8'b0000_0100,
		S_DRAIN = 8'b0000_1000,
		S_RD1   = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_OUT   = 8'b0100_0000,
		S_HOLD  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// unpacked queue word
	logic [1:0]             it_cmd;
	logic                   it_ok;
	logic [AN_W-1:0]        it_ant;
	logic                   it_flag;
	logic [BL_W-1:0]        it_bl;
	logic [SA_W-1:0]        it_sa;
	logic [AA_W-1:0]        it_aa;
	logic signed [SB-1:0]   it_re;
	logic signed [SB-1:0]   it_im;

	assign {it_cmd, it_ok, it_ant, it_flag, it_bl, it_sa, it_aa, it_re, it_im} = item;

	logic [MAX_ANTENNAS-1:0] flags_q;
	logic [CB-1:0]           counts_q [NB];

	// baseline walk
	logic [AN_W-1:0] j_q;
	logic [AN_W-1:0] k_q;
	logic [BL_W-1:0] b_q;
	logic [1:0]      p_q;
	logic [CH_W-1:0] c_q;
	logic            pair_on_q;
	logic [AA_W-1:0] clr_q;

	logic [NW-1:0]   n_use;
	logic [NCW-1:0]  nc_use;
	logic            k_more;
	logic            j_more;
	logic            c_last;
	logic            issue;

	assign n_use  = (int'(antennas_in_use) > MAX_ANTENNAS) ? NW'(MAX_ANTENNAS)
	                                                       : NW'(antennas_in_use);
	assign nc_use = (int'(channels_in_use) > MAX_CHANNELS) ? NCW'(MAX_CHANNELS)
	                                                       : NCW'(channels_in_use);
	assign k_more = (NW'(k_q) + 1'b1) < n_use;
	assign j_more = ((NW + 1)'(j_q) + (NW + 1)'(2)) < (NW + 1)'(n_use);
	assign c_last = ((NCW + 1)'(c_q) + 1'b1) == (NCW + 1)'(nc_use);
	assign issue  = (state_q == S_CORR) && pair_on_q;

	// spectrum store, one copy per operand
	logic [SA_W-1:0]   ia;
	logic [SA_W-1:0]   ib;
	logic [AA_W-1:0]   io;
	logic [2*SB-1:0]   spa_rd;
	logic [2*SB-1:0]   spb_rd;
	logic              spec_we;
	int                ia_full;
	int                ib_full;
	int                io_full;

	always_comb begin
		ia_full = (int'(j_q) * 2 + int'(p_q[1])) * MAX_CHANNELS + int'(c_q);
		ib_full = (int'(k_q) * 2 + int'(p_q[0])) * MAX_CHANNELS + int'(c_q);
		io_full = (int'(b_q) * 4 + int'(p_q)) * MAX_CHANNELS + int'(c_q);
		ia = ia_full[SA_W-1:0];
		ib = ib_full[SA_W-1:0];
		io = io_full[AA_W-1:0];
	end

	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign spec_we  = item_pop && (it_cmd == cc_pkg::CMD_LOAD) && it_ok;

	cc_ram #(.WIDTH(2 * SB), .DEPTH(SD)) u_spec_a (
		.clk   (clk),
		.we    (spec_we),
		.waddr (it_sa),
		.wdata ({it_re, it_im}),
		.raddr (ia),
		.rdata (spa_rd)
	);

	cc_ram #(.WIDTH(2 * SB), .DEPTH(SD)) u_spec_b (
		.clk   (clk),
		.we    (spec_we),
		.waddr (it_sa),
		.wdata ({it_re, it_im}),
		.raddr (ib),
		.rdata (spb_rd)
	);

	// accumulator store, real and imaginary side by side
	logic                   acc_we;
	logic [AA_W-1:0]        acc_waddr;
	logic [2*ACC_BITS-1:0]  acc_wdata;
	logic [AA_W-1:0]        acc_raddr;
	logic [2*ACC_BITS-1:0]  acc_rd;

	cc_ram #(.WIDTH(2 * ACC_BITS), .DEPTH(AD)) u_acc (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rd)
	);

	assign acc_raddr = (state_q == S_CORR) ? io : it_aa;

	// cross-multiply pipeline
	logic                       v_s1, v_s2, v_s3;
	logic [AA_W-1:0]            aa_s1, aa_s2, aa_s3;
	logic [2*ACC_BITS-1:0]      acc_s2, acc_s3;
	logic signed [PW-1:0]       rr_s2, ii_s2, ir_s2, ri_s2;
	logic signed [PW:0]         sre_s3, sim_s3;
	logic signed [SB-1:0]       a_re, a_im, b_re, b_im;
	logic signed [ACC_BITS-1:0] new_re, new_im;

	assign {a_re, a_im} = spa_rd;
	assign {b_re, b_im} = spb_rd;

	function automatic logic signed [ACC_BITS-1:0] sat_add(
		input logic signed [ACC_BITS-1:0] acc,
		input logic signed [PW:0]         p
	);
		logic signed [SW-1:0] sum;
		sum = SW'(acc) + SW'(p);
		// fits when every bit from the accumulator sign upward agrees
		if ((sum[SW-1:ACC_BITS-1] == '0) || (sum[SW-1:ACC_BITS-1] == '1)) begin
			return sum[ACC_BITS-1:0];
		end else if (sum[SW-1]) begin
			return {1'b1, {(ACC_BITS - 1){1'b0}}};
		end else begin
			return {1'b0, {(ACC_BITS - 1){1'b1}}};
		end
	endfunction

	assign new_re = sat_add(acc_s3[2*ACC_BITS-1:ACC_BITS], sre_s3);
	assign new_im = sat_add(acc_s3[ACC_BITS-1:0], sim_s3);

	always_comb begin
		if (state_q == S_CLR) begin
			acc_we    = 1'b1;
			acc_waddr = clr_q;
			acc_wdata = '0;
		end else begin
			acc_we    = v_s3;
			acc_waddr = aa_s3;
			acc_wdata = {new_re, new_im};
		end
	end

	always_ff @(posedge clk) begin
		aa_s1  <= io;
		aa_s2  <= aa_s1;
		acc_s2 <= acc_rd;
		rr_s2  <= a_re * b_re;
		ii_s2  <= a_im * b_im;
		ir_s2  <= a_im * b_re;
		ri_s2  <= a_re * b_im;
		aa_s3  <= aa_s2;
		acc_s3 <= acc_s2;
		sre_s3 <= (PW + 1)'(rr_s2) + (PW + 1)'(ii_s2);
		sim_s3 <= (PW + 1)'(ir_s2) - (PW + 1)'(ri_s2);
	end

	// reads and normalisation
	logic                       rd_ok_q;
	logic [BL_W-1:0]            bl_q;
	logic [BL_W-1:0]            cnt_idx;
	logic [CB-1:0]              cnt_sel;
	logic                       div_start;
	logic                       div_done;
	logic signed [ACC_BITS-1:0] quo_re, quo_im;
	logic signed [ACC_BITS-1:0] pend_re_q, pend_im_q;
	logic [CB-1:0]              pend_cnt_q;
	logic                       out_valid_q;
	logic signed [ACC_BITS-1:0] out_re_q, out_im_q;
	logic [CB-1:0]              out_cnt_q;

	assign cnt_idx   = (state_q == S_CORR) ? b_q : bl_q;
	assign cnt_sel   = counts_q[cnt_idx];
	assign div_start = (state_q == S_RD1) && rd_ok_q && (cnt_sel != '0);

	cc_div #(.ACC_BITS(ACC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_re (acc_rd[2*ACC_BITS-1:ACC_BITS]),
		.num_im (acc_rd[ACC_BITS-1:0]),
		.den    (cnt_sel),
		.done   (div_done),
		.quo_re (quo_re),
		.quo_im (quo_im)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			bl_q    <= it_bl;
			rd_ok_q <= it_ok;
		end
		if (state_q == S_RD1) begin
			if (!rd_ok_q) begin
				pend_re_q  <= '0;
				pend_im_q  <= '0;
				pend_cnt_q <= '0;
			end else begin
				pend_re_q  <= acc_rd[2*ACC_BITS-1:ACC_BITS];
				pend_im_q  <= acc_rd[ACC_BITS-1:0];
				pend_cnt_q <= cnt_sel;
			end
		end else if ((state_q == S_DIV) && div_done) begin
			pend_re_q <= quo_re;
			pend_im_q <= quo_im;
		end
		if ((state_q == S_OUT) && (!out_valid_q || !out_stall)) begin
			out_re_q  <= pend_re_q;
			out_im_q  <= pend_im_q;
			out_cnt_q <= pend_cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign vis_re    = out_re_q;
	assign vis_im    = out_im_q;
	assign fft_count = out_cnt_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			flags_q     <= '0;
			j_q         <= '0;
			k_q         <= '0;
			b_q         <= '0;
			p_q         <= '0;
			c_q         <= '0;
			pair_on_q   <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NB; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == AD - 1) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						case (it_cmd)
							cc_pkg::CMD_CLEAR: begin
								for (int i = 0; i < NB; i++) begin
									counts_q[i] <= '0;
								end
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							cc_pkg::CMD_LOAD: begin
								if (it_ok) begin
									flags_q[it_ant] <= it_flag;
								end
							end
							cc_pkg::CMD_CORRELATE: begin
								j_q       <= '0;
								k_q       <= AN_W'(1);
								b_q       <= '0;
								p_q       <= '0;
								c_q       <= '0;
								pair_on_q <= 1'b0;
								state_q   <= (n_use < NW'(2)) ? S_DRAIN : S_CORR;
							end
							cc_pkg::CMD_READ: begin
								state_q <= S_RD1;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CORR: begin
					if (!pair_on_q) begin
						if (flags_q[j_q] && flags_q[k_q] && (nc_use != '0)) begin
							pair_on_q <= 1'b1;
							p_q       <= '0;
							c_q       <= '0;
						end else begin
							// with no channels a valid pair still counts
							if (flags_q[j_q] && flags_q[k_q] && (cnt_sel != '1)) begin
								counts_q[b_q] <= cnt_sel + 1'b1;
							end
							b_q <= b_q + 1'b1;
							if (k_more) begin
								k_q <= k_q + 1'b1;
							end else if (j_more) begin
								j_q <= j_q + 1'b1;
								k_q <= j_q + AN_W'(2);
							end else begin
								state_q <= S_DRAIN;
							end
						end
					end else if (c_last) begin
						c_q <= '0;
						p_q <= p_q + 1'b1;
						if (p_q == 2'd3) begin
							pair_on_q <= 1'b0;
							if (cnt_sel != '1) begin
								counts_q[b_q] <= cnt_sel + 1'b1;
							end
							b_q <= b_q + 1'b1;
							if (k_more) begin
								k_q <= k_q + 1'b1;
							end else if (j_more) begin
								j_q <= j_q + 1'b1;
								k_q <= j_q + AN_W'(2);
							end else begin
								state_q <= S_DRAIN;
							end
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// hold until every accumulator write has landed
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_IDLE;
					end
				end
				S_RD1: begin
					state_q <= div_start ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_HOLD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/cross_correlate_accumulate_top.sv]
// ----------------------------------------------------------------------------
// cross_correlate_accumulate_top
// Cross-multiply and accumulate stage of an FX correlator.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  cmd .. product
//   out      output     out_valid/out_stall  vis_re, vis_im, fft_count
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// A load is taken without leaving the idle state. A correlate walks every
// baseline, and each product and channel of each valid one, then drains
// the multiply pipeline. A valid read with a nonzero count is normalised
// by the bit-serial divider. A clear, and reset, sweep the accumulator RAM
// at one entry per cycle (baselines x 4 x MAX_CHANNELS, 1536 by default)
// while no word leaves the queue; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module cross_correlate_accumulate_top #(
	parameter int MAX_ANTENNAS = cc_pkg::MAX_ANTENNAS_DEF,
	parameter int MAX_CHANNELS = cc_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = cc_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_BITS     = cc_pkg::ACC_BITS_DEF,
	localparam int NB   = MAX_ANTENNAS * (MAX_ANTENNAS - 1) / 2,
	localparam int SD   = MAX_ANTENNAS * 2 * MAX_CHANNELS,
	localparam int AD   = NB * 4 * MAX_CHANNELS,
	localparam int AN_W = $clog2(MAX_ANTENNAS),
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	localparam int BL_W = (NB > 1) ? $clog2(NB) : 1,
	localparam int SA_W = $clog2(SD),
	localparam int AA_W = (AD > 1) ? $clog2(AD) : 1,
	localparam int IW   = 2 + 1 + AN_W + 1 + BL_W + SA_W + AA_W + 2 * SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [cc_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [AN_W-1:0]                antenna,
	input  logic                           polarisation,
	input  logic [CH_W-1:0]                channel,
	input  logic signed [SAMPLE_BITS-1:0]  sample_re,
	input  logic signed [SAMPLE_BITS-1:0]  sample_im,
	input  logic                           antenna_ok,
	input  logic [BL_W-1:0]                baseline,
	input  logic [1:0]                     product,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [ACC_BITS-1:0]     vis_re,
	output logic signed [ACC_BITS-1:0]     vis_im,
	output logic [cc_pkg::CNT_BITS-1:0]    fft_count
);

	logic [cc_pkg::ANT_CFG_BITS-1:0]  ant_cfg_q;
	logic [cc_pkg::CHAN_CFG_BITS-1:0] chan_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ant_cfg_q  <= cc_pkg::ANT_CFG_RESET;
			chan_cfg_q <= cc_pkg::CHAN_CFG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == cc_pkg::REG_ANTENNAS) begin
				ant_cfg_q <= cfg_data[cc_pkg::ANT_CFG_BITS-1:0];
			end else begin
				chan_cfg_q <= cfg_data[cc_pkg::CHAN_CFG_BITS-1:0];
			end
		end
	end

	logic          push;
	logic          full;
	logic [IW-1:0] front_word;
	logic [IW-1:0] queue_word;
	logic          queue_nonempty;
	logic          pop;

	cc_front #(
		.MAX_ANTENNAS (MAX_ANTENNAS),
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.antenna      (antenna),
		.polarisation (polarisation),
		.channel      (channel),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.antenna_ok   (antenna_ok),
		.baseline     (baseline),
		.product      (product),
		.push         (push),
		.full         (full),
		.item         (front_word)
	);

	cc_queue #(.WIDTH(IW), .DEPTH(cc_pkg::QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (front_word),
		.full     (full),
		.pop      (pop),
		.nonempty (queue_nonempty),
		.rdata    (queue_word)
	);

	cc_back #(
		.MAX_ANTENNAS (MAX_ANTENNAS),
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.ACC_BITS     (ACC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (queue_word),
		.item_valid      (queue_nonempty),
		.item_pop        (pop),
		.antennas_in_use (ant_cfg_q),
		.channels_in_use (chan_cfg_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.vis_re          (vis_re),
		.vis_im          (vis_im),
		.fft_count       (fft_count)
	);

endmodule
